### rtl/pcs_pkg.sv
// Shared types, widths and constants of the phase current sense block.
`default_nettype none
package pcs_pkg;

  localparam int ADC_BITS   = 12;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = 16;
  localparam int OFS_W      = 16;
  localparam int SCALE_W    = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int Q4_BITS    = 4;
  localparam int FRAC_SHIFT = 20;

  // raw value in Q.4, signed difference against a Q12.4 offset
  localparam int RAW_Q4_W = ADC_BITS + Q4_BITS;
  localparam int DIFF_W   = ((RAW_Q4_W > OFS_W) ? RAW_Q4_W : OFS_W) + 1;
  localparam int PROD_W   = DIFF_W + SCALE_W + 1;
  localparam int MA_W     = PROD_W - FRAC_SHIFT;
  localparam int MRG_W    = MA_W + 2;

  // divider for the offset average: sum * 16 / count
  localparam int DIV_W     = SUM_W + Q4_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [CNT_W-1:0]   DEFAULT_SAMPLES = CNT_W'(100);
  localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(264046);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_SCALE        = 2'd1,
    CFG_PHASE_SWAP   = 2'd2
  } cfg_idx_e;

  // per-lane operation strobes
  typedef struct packed {
    logic acc;   // add raw value to the running sum
    logic fin;   // last calibration sample: start the average
    logic mul;   // register offset-corrected product
  } lane_ctrl_t;

  // control for the result register
  typedef struct packed {
    logic load;
    logic cal_item;
    logic is_cal;
    logic done;
  } merge_ctrl_t;

  localparam logic signed [MRG_W-1:0] SAT_HI = MRG_W'(32'sh7FFF_FFFF);
  localparam logic signed [MRG_W-1:0] SAT_LO = MRG_W'(32'sh8000_0000);

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MRG_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/pcs_in_if.sv
// Input channel: one ADC conversion pair and its command.
`default_nettype none
interface pcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [pcs_pkg::ADC_BITS-1:0]  first_word;
  logic [pcs_pkg::ADC_BITS-1:0]  second_word;

  modport source (output valid, cmd, first_word, second_word, input ready);
  modport sink   (input valid, cmd, first_word, second_word, output ready);
endinterface
`default_nettype wire

### rtl/pcs_out_if.sv
// Output channel: three phase currents and calibration status.
`default_nettype none
interface pcs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pcs_pkg::OUT_W-1:0] phase_a_ma;
  logic signed [pcs_pkg::OUT_W-1:0] phase_b_ma;
  logic signed [pcs_pkg::OUT_W-1:0] phase_c_ma;
  logic                             is_calibrated;
  logic                             cal_complete;

  modport source (output valid, phase_a_ma, phase_b_ma, phase_c_ma, is_calibrated,
                  cal_complete, input ready);
  modport sink   (input valid, phase_a_ma, phase_b_ma, phase_c_ma, is_calibrated,
                  cal_complete, output ready);
endinterface
`default_nettype wire

### rtl/pcs_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
`default_nettype none
module pcs_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pcs_pkg::DIV_W-1:0]     dividend_i,
  input  wire logic [pcs_pkg::CNT_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [pcs_pkg::OFS_W-1:0]          quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [pcs_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [pcs_pkg::CNT_W-1:0]       rem_q, rem_d;
  logic [pcs_pkg::CNT_W-1:0]       den_q, den_d;
  logic [pcs_pkg::DIV_W-1:0]       quo_q, quo_d;
  logic [pcs_pkg::CNT_W:0]         trial;
  logic                            ge;

  always_comb begin
    trial  = {rem_q, quo_q[pcs_pkg::DIV_W-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = ge ? pcs_pkg::CNT_W'(trial - {1'b0, den_q}) : trial[pcs_pkg::CNT_W-1:0];
      quo_d = {quo_q[pcs_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[pcs_pkg::DIV_W-1:pcs_pkg::OFS_W]) ? '1
                                                             : quo_q[pcs_pkg::OFS_W-1:0];

endmodule
`default_nettype wire

### rtl/pcs_lane.sv
// One phase lane: calibration sum, offset average and offset-corrected scaling.
`default_nettype none
module pcs_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pcs_pkg::lane_ctrl_t                 ctrl_i,
  input  wire logic [pcs_pkg::ADC_BITS-1:0]        raw_i,
  input  wire logic [pcs_pkg::SCALE_W-1:0]         scale_i,
  input  wire logic [pcs_pkg::CNT_W-1:0]           count_i,
  output logic                                     done_o,
  output logic signed [pcs_pkg::MA_W-1:0]          ma_o
);

  logic [pcs_pkg::SUM_W-1:0]          sum_q, sum_d, sum_nx;
  logic [pcs_pkg::OFS_W-1:0]          offset_q;
  logic [pcs_pkg::OFS_W-1:0]          quot;
  logic                               div_done;
  logic [pcs_pkg::DIV_W-1:0]          dividend;
  logic signed [pcs_pkg::DIFF_W-1:0]  diff;
  logic signed [pcs_pkg::PROD_W-1:0]  prod_q, prod_d;

  assign sum_nx   = sum_q + pcs_pkg::SUM_W'(raw_i);
  assign dividend = pcs_pkg::DIV_W'(sum_nx) << pcs_pkg::Q4_BITS;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.acc) begin
      sum_d = ctrl_i.fin ? '0 : sum_nx;
    end
  end

  pcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.acc & ctrl_i.fin),
    .dividend_i (dividend),
    .divisor_i  (count_i),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      offset_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (div_done) begin
        offset_q <= quot;
      end
    end
  end

  // raw in Q.4 minus offset, then times the Q16.16 scale
  assign diff = $signed(pcs_pkg::DIFF_W'(pcs_pkg::RAW_Q4_W'(raw_i) << pcs_pkg::Q4_BITS))
              - $signed(pcs_pkg::DIFF_W'(offset_q));
  assign prod_d = pcs_pkg::PROD_W'(diff)
                * pcs_pkg::PROD_W'($signed({1'b0, scale_i}));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign ma_o   = prod_q[pcs_pkg::PROD_W-1:pcs_pkg::FRAC_SHIFT];
  assign done_o = div_done;

endmodule
`default_nettype wire

### rtl/pcs_merge.sv
// Merge stage: derive phase C, saturate, and hold the result register.
`default_nettype none
module pcs_merge (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pcs_pkg::merge_ctrl_t             ctrl_i,
  input  wire logic signed [pcs_pkg::MA_W-1:0]  a_i,
  input  wire logic signed [pcs_pkg::MA_W-1:0]  b_i,
  output logic                                  free_o,
  pcs_out_if.source                             out_o
);

  logic                               valid_q, valid_d;
  logic signed [pcs_pkg::MRG_W-1:0]   a_x, b_x, c_x;
  logic signed [pcs_pkg::OUT_W-1:0]   a_q, b_q, c_q;
  logic                               is_cal_q, done_q;

  assign a_x = pcs_pkg::MRG_W'(a_i);
  assign b_x = pcs_pkg::MRG_W'(b_i);
  assign c_x = -(a_x + b_x);

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (ctrl_i.load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q      <= ctrl_i.cal_item ? '0 : pcs_pkg::sat_out(a_x);
      b_q      <= ctrl_i.cal_item ? '0 : pcs_pkg::sat_out(b_x);
      c_q      <= ctrl_i.cal_item ? '0 : pcs_pkg::sat_out(c_x);
      is_cal_q <= ctrl_i.is_cal;
      done_q   <= ctrl_i.done;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.phase_a_ma    = a_q;
  assign out_o.phase_b_ma    = b_q;
  assign out_o.phase_c_ma    = c_q;
  assign out_o.is_calibrated = is_cal_q;
  assign out_o.cal_complete  = done_q;

endmodule
`default_nettype wire

### rtl/phase_current_sense_with_offset_cal.sv
// Top level: two-shunt phase current sensing with offset calibration.
`default_nettype none
// Flow: a convert transaction runs through the multiply state, a calibration one through
//   the sum state, to the result hand-off; one that closes a run first waits on the 32-step dividers.
// In flight: one transaction at a time, accepted only in the idle state; the result register
//   lets the next one in while its result waits to be taken.
// Reset: asynchronous, active low; clears sums, offsets, sample counter and calibrated
//   flag, and loads the register defaults (100 samples, scale 264046).
module phase_current_sense_with_offset_cal (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  pcs_in_if.sink                                   in_i,
  pcs_out_if.source                                out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [pcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [pcs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  // One-hot sequencer: idle, calibration sum, divide, multiply, result hand-off.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CAL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [pcs_pkg::CNT_W-1:0]    sample_count_q;
  logic [pcs_pkg::SCALE_W-1:0]  scale_q;
  logic                         swap_q;

  // latched transaction
  logic                             cmd_q;
  logic [pcs_pkg::ADC_BITS-1:0]     raw_a_q, raw_b_q;

  // calibration bookkeeping
  logic [pcs_pkg::CNT_W-1:0]    seen_q, seen_d, seen_inc;
  logic [pcs_pkg::CNT_W-1:0]    n_eff;
  logic                         fin;
  logic                         calibrated_q, calibrated_d;
  logic                         done_q, done_d;

  pcs_pkg::lane_ctrl_t          lane_ctrl;
  pcs_pkg::merge_ctrl_t         mrg_ctrl;
  logic                         done_a, done_b;
  logic signed [pcs_pkg::MA_W-1:0] ma_a, ma_b;
  logic                         out_free;
  logic                         in_acc;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= pcs_pkg::DEFAULT_SAMPLES;
      scale_q        <= pcs_pkg::SCALE_RST;
      swap_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pcs_pkg::cfg_idx_e'(cfg_idx_i))
        pcs_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i[pcs_pkg::CNT_W-1:0];
        pcs_pkg::CFG_SCALE:        scale_q        <= cfg_wdata_i[pcs_pkg::SCALE_W-1:0];
        pcs_pkg::CFG_PHASE_SWAP:   swap_q         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A count of zero means the default run length. The count is read on every
  // calibration item, so lowering it mid-run closes the run at once.
  assign n_eff    = (sample_count_q == '0) ? pcs_pkg::DEFAULT_SAMPLES : sample_count_q;
  assign seen_inc = seen_q + 1'b1;
  assign fin      = seen_inc >= n_eff;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Route the conversion pair to phases A and B at acceptance.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= in_i.cmd;
      raw_a_q <= swap_q ? in_i.second_word : in_i.first_word;
      raw_b_q <= swap_q ? in_i.first_word  : in_i.second_word;
    end
  end

  always_comb begin
    state_d      = state_q;
    seen_d       = seen_q;
    calibrated_d = calibrated_q;
    done_d       = done_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          done_d  = 1'b0;
          state_d = in_i.cmd ? S_CAL : S_MUL;
        end
      end
      S_CAL: begin
        // Sums advance in the lanes this cycle; the last sample kicks the dividers.
        if (fin) begin
          seen_d  = '0;
          state_d = S_DIV;
        end else begin
          seen_d  = seen_inc;
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (done_a) begin
          calibrated_d = 1'b1;
          done_d       = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_MUL: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      seen_q       <= '0;
      calibrated_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      seen_q       <= seen_d;
      calibrated_q <= calibrated_d;
      done_q       <= done_d;
    end
  end

  assign lane_ctrl.acc = (state_q == S_CAL);
  assign lane_ctrl.fin = fin;
  assign lane_ctrl.mul = (state_q == S_MUL);

  pcs_lane u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .raw_i   (raw_a_q),
    .scale_i (scale_q),
    .count_i (n_eff),
    .done_o  (done_a),
    .ma_o    (ma_a)
  );

  pcs_lane u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .raw_i   (raw_b_q),
    .scale_i (scale_q),
    .count_i (n_eff),
    .done_o  (done_b),
    .ma_o    (ma_b)
  );

  // Hand the finished transaction to the result register.
  assign mrg_ctrl.load     = (state_q == S_OUT) && out_free;
  assign mrg_ctrl.cal_item = cmd_q;
  assign mrg_ctrl.is_cal   = calibrated_q;
  assign mrg_ctrl.done     = done_q;

  pcs_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mrg_ctrl),
    .a_i    (ma_a),
    .b_i    (ma_b),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // Both lanes divide the same number of steps and must finish together.
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_a == done_b)
    else $error("lane dividers out of step");

  // A transaction that closes a run reports the block as calibrated.
  a_done_implies_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.cal_complete |-> out_o.is_calibrated)
    else $error("cal_complete without is_calibrated");

  // One transaction in flight: no acceptance right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second transaction accepted while busy");

  // The dividers only report while the sequencer waits for them.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_a |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

endmodule
`default_nettype wire
